/* sv/crbs_pkg.sv */
`timescale 1ns / 1ps
// Package for component_relabel_by_size: field widths, commands, item types.
// Used by the channel interfaces and the RAM-based top level.
package crbs_pkg;

	localparam int LABEL_COUNT_DEF = 4096;
	localparam int COUNT_BITS_DEF  = 24;

	localparam int CMD_W   = 2;
	localparam int LABEL_W = 12;
	localparam int RANK_W  = 13;
	localparam int KEEP_W  = 14;

	localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MAP    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	localparam logic [KEEP_W-1:0] KEEP_RESET = '1; // -1: keep all

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [LABEL_W-1:0] voxel_label;
	} in_item_t;

	typedef struct packed {
		logic [RANK_W-1:0] new_label;
		logic [RANK_W-1:0] label_limit;
	} out_item_t;

endpackage

/* sv/crbs_in_if.sv */
`timescale 1ns / 1ps
// Input channel: valid/ready handshake with one in_item_t payload.
// Depends on crbs_pkg.
interface crbs_in_if import crbs_pkg::*;;
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* sv/crbs_out_if.sv */
`timescale 1ns / 1ps
// Output channel: valid/ready handshake with one out_item_t payload.
// Depends on crbs_pkg.
interface crbs_out_if import crbs_pkg::*;;
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* sv/crbs_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module crbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/component_relabel_by_size.sv */
`timescale 1ns / 1ps
// Relabels connected components by size; a histogram RAM and a rank RAM.
// Depends on crbs_pkg, crbs_in_if, crbs_out_if and crbs_ram.
//
// Items carry a command and a voxel label. Count items stream at one per
// cycle while no map is in flight and the result slot is free, through a
// read-modify-write of the histogram RAM (registered read, back-to-back
// hits on the same label forwarded from the last write). Map items read
// the rank RAM and return one result; no item is taken while a map's read
// is in flight or the single output register waits to be drained. Finish
// sweeps the histogram RAM: one pass zeroes the rank RAM and finds the
// largest count, then one pass per kept distinct count assigns ranks in
// label order; finish then returns the label limit as one result. Clear,
// and the clearing pass after reset, write zeros over the histogram,
// during which no item is taken (keep_sizes writes still are). Map gives
// zero for label zero, a label out of range or one the last finish did
// not rank; before any finish, map of another label is undefined.
module component_relabel_by_size import crbs_pkg::*; #(
	parameter int LABEL_COUNT = LABEL_COUNT_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	crbs_in_if.sink           voxels,
	crbs_out_if.source        results,
	input  logic              keep_sizes_we,
	input  logic [KEEP_W-1:0] keep_sizes
);

	localparam int AW = $clog2(LABEL_COUNT);
	localparam int LW = (AW > LABEL_W) ? AW : LABEL_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(LABEL_COUNT - 1);

	// controller states
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2; // zero ranks, find top count
	localparam logic [1:0] ST_RANK  = 2'd3; // rank labels of one count

	logic [1:0]            state_q;
	logic [AW-1:0]         addr_q;      // sweep / clear address
	logic                  issue_q;     // sweep still issuing reads
	logic                  sw_vld_s1;
	logic                  sw_last_s1;
	logic [AW-1:0]         sw_addr_s1;

	logic                  cnt_vld_s1;  // count read in flight
	logic [AW-1:0]         cnt_addr_s1;
	logic                  fwd_vld_q;
	logic [AW-1:0]         fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;

	logic                  map_vld_s1;
	logic                  map_zero_s1;

	logic [COUNT_BITS-1:0] cur_q;       // count being ranked
	logic [COUNT_BITS-1:0] nmax_q;      // largest count below cur_q
	logic [RANK_W-1:0]     dist_q;      // distinct-size index of cur_q
	logic [RANK_W-1:0]     next_rank_q;
	logic [KEEP_W-1:0]     keep_q;

	logic                  out_vld_q;
	out_item_t             out_q;

	// RAM ports
	logic                  cnt_we;
	logic [AW-1:0]         cnt_waddr, cnt_raddr;
	logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
	logic                  rk_we;
	logic [AW-1:0]         rk_waddr;
	logic [RANK_W-1:0]     rk_wdata, rk_rdata;

	logic                  acc;
	logic [LW-1:0]         lab_ext;
	logic [AW-1:0]         lab_idx;
	logic                  in_range;
	logic [COUNT_BITS-1:0] cnt_cur, cnt_inc;
	logic                  hit_cur;
	logic [COUNT_BITS-1:0] nmax_nx;
	logic [RANK_W-1:0]     next_rank_nx;
	logic [RANK_W-1:0]     dist_nx;
	logic                  kept_nx;
	logic                  sweep_done;
	logic                  finish_done;

	assign acc      = voxels.valid & voxels.ready;
	assign lab_ext  = LW'(voxels.payload.voxel_label);
	assign lab_idx  = lab_ext[AW-1:0];
	assign in_range = (32'(voxels.payload.voxel_label) < LABEL_COUNT);

	// take items only when idle, with no map in flight, and the result slot will be free
	assign voxels.ready = (state_q == ST_IDLE) && !map_vld_s1 &&
		(!out_vld_q || results.ready);
	assign results.valid   = out_vld_q;
	assign results.payload = out_q;

	crbs_ram #(.WIDTH(COUNT_BITS), .DEPTH(LABEL_COUNT)) u_counts (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	crbs_ram #(.WIDTH(RANK_W), .DEPTH(LABEL_COUNT)) u_ranks (
		.clk   (clk),
		.we    (rk_we),
		.waddr (rk_waddr),
		.wdata (rk_wdata),
		.raddr (lab_idx),
		.rdata (rk_rdata)
	);

	// histogram read-modify-write, saturating
	assign hit_cur = fwd_vld_q && (fwd_addr_q == cnt_addr_s1);
	assign cnt_cur = hit_cur ? fwd_data_q : cnt_rdata;
	assign cnt_inc = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
	assign cnt_raddr = issue_q ? addr_q : lab_idx;

	always_comb begin
		if (state_q == ST_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = addr_q;
			cnt_wdata = '0;
		end else begin
			cnt_we    = cnt_vld_s1;
			cnt_waddr = cnt_addr_s1;
			cnt_wdata = cnt_inc;
		end
	end

	// sweep datapath
	always_comb begin
		rk_we        = 1'b0;
		rk_waddr     = sw_addr_s1;
		rk_wdata     = '0;
		nmax_nx      = nmax_q;
		next_rank_nx = next_rank_q;
		if (sw_vld_s1) begin
			if (state_q == ST_ZERO) begin
				rk_we = 1'b1;
				if (cnt_rdata > nmax_q) begin
					nmax_nx = cnt_rdata;
				end
			end else begin
				if (cnt_rdata == cur_q) begin
					rk_we        = 1'b1;
					rk_wdata     = next_rank_q;
					next_rank_nx = next_rank_q + RANK_W'(1);
				end else if (cnt_rdata < cur_q && cnt_rdata > nmax_q) begin
					nmax_nx = cnt_rdata;
				end
			end
		end
	end

	assign dist_nx     = (state_q == ST_ZERO) ? '0 : dist_q + RANK_W'(1);
	// negative keep keeps every size
	assign kept_nx     = keep_q[KEEP_W-1] || ({1'b0, dist_nx} < keep_q);
	assign sweep_done  = sw_vld_s1 && sw_last_s1;
	assign finish_done = sweep_done && ((nmax_nx == '0) || !kept_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			issue_q     <= 1'b0;
			sw_vld_s1   <= 1'b0;
			cnt_vld_s1  <= 1'b0;
			fwd_vld_q   <= 1'b0;
			map_vld_s1  <= 1'b0;
			next_rank_q <= RANK_W'(1);
			keep_q      <= KEEP_RESET;
			out_vld_q   <= 1'b0;
		end else begin
			if (keep_sizes_we) begin
				keep_q <= keep_sizes;
			end

			cnt_vld_s1 <= acc && (voxels.payload.command == CMD_COUNT) && in_range;
			fwd_vld_q  <= cnt_vld_s1;
			map_vld_s1 <= acc && (voxels.payload.command == CMD_MAP);

			sw_vld_s1 <= issue_q;
			if (issue_q) begin
				addr_q <= addr_q + AW'(1);
				if (addr_q == LAST_ADDR) begin
					issue_q <= 1'b0;
				end
			end

			if (out_vld_q && results.ready) begin
				out_vld_q <= 1'b0;
			end
			if (map_vld_s1 || finish_done) begin
				out_vld_q <= 1'b1;
			end

			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc && voxels.payload.command == CMD_FINISH) begin
						state_q     <= ST_ZERO;
						addr_q      <= '0;
						issue_q     <= 1'b1;
						next_rank_q <= RANK_W'(1);
					end else if (acc && voxels.payload.command == CMD_CLEAR) begin
						state_q <= ST_CLEAR;
						addr_q  <= '0;
					end
				end
				ST_ZERO, ST_RANK: begin
					next_rank_q <= next_rank_nx;
					if (finish_done) begin
						state_q <= ST_IDLE;
					end else if (sweep_done) begin
						state_q <= ST_RANK;
						addr_q  <= '0;
						issue_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cnt_addr_s1 <= lab_idx;
		fwd_addr_q  <= cnt_addr_s1;
		fwd_data_q  <= cnt_inc;
		map_zero_s1 <= (voxels.payload.voxel_label == '0) || !in_range;
		sw_addr_s1  <= addr_q;
		sw_last_s1  <= (addr_q == LAST_ADDR);

		if (acc && voxels.payload.command == CMD_FINISH) begin
			nmax_q <= '0;
		end else if (sweep_done) begin
			cur_q  <= nmax_nx;
			nmax_q <= '0;
			dist_q <= dist_nx;
		end else begin
			nmax_q <= nmax_nx;
		end

		if (map_vld_s1) begin
			out_q.new_label   <= map_zero_s1 ? '0 : rk_rdata;
			out_q.label_limit <= '0;
		end else if (finish_done) begin
			out_q.new_label   <= '0;
			out_q.label_limit <= next_rank_nx;
		end
	end

endmodule
